// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; clock is clk, reset is rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/rlpe_pkg.sv =====
// ----------------------------------------------------------------------------
// rlpe_pkg
// Types, codes, tables and constants of the RGB LED pattern engine.
// ----------------------------------------------------------------------------
package rlpe_pkg;

  typedef enum logic [1:0] {
    REG_COLOR   = 2'd0,
    REG_PATTERN = 2'd1,
    REG_BRIGHT  = 2'd2
  } reg_index_e;

  typedef enum logic [2:0] {
    PAT_SOLID      = 3'd0,
    PAT_BLINK_SLOW = 3'd1,
    PAT_BLINK_FAST = 3'd2,
    PAT_PULSE      = 3'd3,
    PAT_FADE       = 3'd4,
    PAT_RAINBOW    = 3'd5
  } pattern_e;

  typedef enum logic [2:0] {
    COL_OFF    = 3'd0,
    COL_RED    = 3'd1,
    COL_GREEN  = 3'd2,
    COL_BLUE   = 3'd3,
    COL_YELLOW = 3'd4,
    COL_PURPLE = 3'd5,
    COL_CYAN   = 3'd6,
    COL_WHITE  = 3'd7
  } color_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADVANCE,
    ST_HUE,
    ST_BASE,
    ST_MUL1,
    ST_DIV1,
    ST_MUL2,
    ST_DIV2,
    ST_OUT
  } state_e;

  // Controller to datapath commands, at most one set per cycle
  typedef struct packed {
    logic take_in;
    logic advance;
    logic hue;
    logic base;
    logic mul_level;
    logic mul_bright;
    logic div;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } rgb_t;

  typedef struct packed {
    logic [9:0] interval;
    logic [3:0] inc;
    logic [8:0] modulus;
  } timing_t;

  localparam logic [2:0] COLOR_RESET   = COL_BLUE;
  localparam logic [2:0] PATTERN_RESET = PAT_PULSE;
  localparam logic [6:0] BRIGHT_RESET  = 7'd80;
  localparam logic [6:0] PCT_FULL      = 7'd100;
  localparam logic [7:0] DUTY_MAX      = 8'd255;

  // floor(x/100) = (x*5243) >> 19 for x <= 25500
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int          RECIP_100_SHIFT = 19;
  // floor(h/60) = (h*1093) >> 16 for h < 512
  localparam logic [10:0] RECIP_60  = 11'd1093;
  // floor(s/5) = (s*205) >> 10 for s < 512
  localparam logic [7:0]  RECIP_5   = 8'd205;

  localparam int PULSE_LEN = 72;
  localparam logic [6:0] PULSE_TAB [PULSE_LEN] = '{
    7'd50, 7'd54, 7'd58, 7'd62, 7'd67, 7'd71, 7'd75, 7'd78, 7'd82, 7'd85,
    7'd88, 7'd90, 7'd93, 7'd95, 7'd96, 7'd98, 7'd99, 7'd99, 7'd100, 7'd99,
    7'd99, 7'd98, 7'd96, 7'd95, 7'd93, 7'd90, 7'd88, 7'd85, 7'd82, 7'd78,
    7'd75, 7'd71, 7'd67, 7'd62, 7'd58, 7'd54, 7'd50, 7'd45, 7'd41, 7'd37,
    7'd32, 7'd28, 7'd25, 7'd21, 7'd17, 7'd14, 7'd11, 7'd9, 7'd6, 7'd4,
    7'd3, 7'd1, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd1, 7'd3, 7'd4,
    7'd6, 7'd9, 7'd11, 7'd14, 7'd17, 7'd21, 7'd25, 7'd28, 7'd32, 7'd37,
    7'd41, 7'd45
  };

  function automatic rgb_t palette(input logic [2:0] col);
    rgb_t c;
    c = '0;
    unique case (col)
      COL_OFF:    c = '0;
      COL_RED:    c.r = DUTY_MAX;
      COL_GREEN:  c.g = DUTY_MAX;
      COL_BLUE:   c.b = DUTY_MAX;
      COL_YELLOW: begin
        c.r = DUTY_MAX;
        c.g = DUTY_MAX;
      end
      COL_PURPLE: begin
        c.r = DUTY_MAX;
        c.b = DUTY_MAX;
      end
      COL_CYAN: begin
        c.g = DUTY_MAX;
        c.b = DUTY_MAX;
      end
      default: begin
        c.r = DUTY_MAX;
        c.g = DUTY_MAX;
        c.b = DUTY_MAX;
      end
    endcase
    return c;
  endfunction

  // inc of zero means the pattern never advances
  function automatic timing_t pattern_timing(input logic [2:0] pat);
    timing_t t;
    t = '{interval: 10'd0, inc: 4'd0, modulus: 9'd1};
    unique case (pat)
      PAT_BLINK_SLOW: t = '{interval: 10'd1000, inc: 4'd1,  modulus: 9'd2};
      PAT_BLINK_FAST: t = '{interval: 10'd250,  inc: 4'd1,  modulus: 9'd2};
      PAT_PULSE:      t = '{interval: 10'd50,   inc: 4'd5,  modulus: 9'd360};
      PAT_FADE:       t = '{interval: 10'd100,  inc: 4'd1,  modulus: 9'd200};
      PAT_RAINBOW:    t = '{interval: 10'd100,  inc: 4'd10, modulus: 9'd360};
      default:        t = '{interval: 10'd0,    inc: 4'd0,  modulus: 9'd1};
    endcase
    return t;
  endfunction

endpackage

// ===== sv/rlpe_ctrl.sv =====
// ----------------------------------------------------------------------------
// rlpe_ctrl
// Sequencer for one tick: advance, hue, base color, two scaling passes, output.
// ----------------------------------------------------------------------------
module rlpe_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output rlpe_pkg::dp_cmd_t cmd
);
  import rlpe_pkg::*;

  state_e state;
  state_e state_next;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.take_in = 1'b1;
          state_next  = ST_ADVANCE;
        end
      end
      ST_ADVANCE: begin
        cmd.advance = 1'b1;
        state_next  = ST_HUE;
      end
      ST_HUE: begin
        cmd.hue    = 1'b1;
        state_next = ST_BASE;
      end
      ST_BASE: begin
        cmd.base   = 1'b1;
        state_next = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.mul_level = 1'b1;
        state_next    = ST_DIV1;
      end
      ST_DIV1: begin
        cmd.div    = 1'b1;
        state_next = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul_bright = 1'b1;
        state_next     = ST_DIV2;
      end
      ST_DIV2: begin
        cmd.div    = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        // wait here while the previous result is still unclaimed
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== sv/rlpe_datapath.sv =====
// ----------------------------------------------------------------------------
// rlpe_datapath
// Config registers, step timing, color generation and 3-lane percent scaler.
// ----------------------------------------------------------------------------
module rlpe_datapath (
  input  logic              clk,
  input  logic              rst,
  input  rlpe_pkg::dp_cmd_t cmd,
  input  logic [31:0]       s_tdata,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [6:0]        cfg_data,
  output logic [23:0]       m_tdata
);
  import rlpe_pkg::*;

  logic [2:0]  color_select;
  logic [2:0]  pattern_select;
  logic [6:0]  global_brightness;
  logic [8:0]  step_count;
  logic [31:0] last_advance_time;
  logic        first_tick_pending;
  logic [31:0] timestamp;
  logic [2:0]  sector;
  logic [6:0]  level;
  logic [7:0]  base   [3];
  logic [14:0] prod   [3];
  logic [7:0]  scaled [3];
  rgb_t        duty;

  timing_t     timing;
  logic [31:0] delta;
  logic        do_advance;
  logic [9:0]  step_sum;
  logic [8:0]  step_next;
  logic [19:0] hue_prod;

  logic [6:0]  level_next;
  rgb_t        base_next;
  logic [8:0]  sector_base;
  logic [5:0]  hue_ofs;
  logic [5:0]  hue_rem;
  logic [7:0]  rise;
  logic [7:0]  fall;
  logic [16:0] pulse_prod;
  logic [6:0]  pulse_idx;

  // ---- step timing ----
  always_comb begin
    timing     = pattern_timing(pattern_select);
    delta      = timestamp - last_advance_time;
    do_advance = (timing.inc != 4'd0) &&
                 (first_tick_pending || (delta >= {22'd0, timing.interval}));
    step_sum   = {1'b0, step_count} + {6'd0, timing.inc};
    if (step_sum >= {1'b0, timing.modulus}) begin
      step_next = 9'(step_sum - {1'b0, timing.modulus});
    end else begin
      step_next = step_sum[8:0];
    end
    hue_prod = 20'(step_count) * 20'(RECIP_60);
  end

  // ---- level and base color ----
  always_comb begin
    sector_base = 9'(9'(sector) * 9'd60);
    hue_ofs     = 6'(step_count - sector_base);
    hue_rem     = 6'd60 - hue_ofs;
    rise        = 8'((10'(hue_ofs) * 10'd17) >> 2);
    fall        = 8'((10'(hue_rem) * 10'd17) >> 2);
    pulse_prod  = 17'(step_count) * 17'(RECIP_5);
    pulse_idx   = pulse_prod[16:10];
    level_next  = PCT_FULL;
    base_next   = palette(color_select);
    case (pattern_select)
      PAT_SOLID: ;
      PAT_BLINK_SLOW, PAT_BLINK_FAST: begin
        if (step_count == 9'd0) begin
          base_next = '0;
        end
      end
      PAT_PULSE: begin
        level_next = (pulse_idx < 7'(PULSE_LEN)) ? PULSE_TAB[pulse_idx] : 7'd0;
      end
      PAT_FADE: begin
        if (step_count < 9'd100) begin
          level_next = 7'(step_count);
        end else if (step_count <= 9'd200) begin
          level_next = 7'(9'd200 - step_count);
        end else begin
          level_next = 7'd0;
        end
      end
      PAT_RAINBOW: begin
        case (sector)
          3'd0:    base_next = '{r: DUTY_MAX, g: rise,     b: 8'd0};
          3'd1:    base_next = '{r: fall,     g: DUTY_MAX, b: 8'd0};
          3'd2:    base_next = '{r: 8'd0,     g: DUTY_MAX, b: rise};
          3'd3:    base_next = '{r: 8'd0,     g: fall,     b: DUTY_MAX};
          3'd4:    base_next = '{r: rise,     g: 8'd0,     b: DUTY_MAX};
          default: base_next = '{r: DUTY_MAX, g: 8'd0,     b: fall};
        endcase
      end
      default: base_next = '0;
    endcase
  end

  // ---- config and step state ----
  always_ff @(posedge clk) begin
    if (rst) begin
      color_select       <= COLOR_RESET;
      pattern_select     <= PATTERN_RESET;
      global_brightness  <= BRIGHT_RESET;
      step_count         <= '0;
      last_advance_time  <= '0;
      first_tick_pending <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COLOR: begin
          color_select       <= cfg_data[2:0];
          step_count         <= '0;
          last_advance_time  <= '0;
          first_tick_pending <= 1'b1;
        end
        REG_PATTERN: begin
          pattern_select     <= cfg_data[2:0];
          step_count         <= '0;
          last_advance_time  <= '0;
          first_tick_pending <= 1'b1;
        end
        REG_BRIGHT: begin
          if (cfg_data <= PCT_FULL) begin
            global_brightness <= cfg_data;
          end
        end
        default: ;
      endcase
    end else if (cmd.advance && do_advance) begin
      step_count         <= step_next;
      last_advance_time  <= timestamp;
      first_tick_pending <= 1'b0;
    end
  end

  // ---- payload pipeline ----
  always_ff @(posedge clk) begin
    logic [27:0] quot;
    if (cmd.take_in) begin
      timestamp <= s_tdata;
    end
    if (cmd.hue) begin
      sector <= hue_prod[18:16];
    end
    if (cmd.base) begin
      level   <= level_next;
      base[0] <= base_next.r;
      base[1] <= base_next.g;
      base[2] <= base_next.b;
    end
    for (int i = 0; i < 3; i++) begin
      if (cmd.mul_level) begin
        prod[i] <= 15'(base[i]) * 15'(level);
      end else if (cmd.mul_bright) begin
        prod[i] <= 15'(scaled[i]) * 15'(global_brightness);
      end
      if (cmd.div) begin
        quot = 28'(prod[i]) * 28'(RECIP_100);
        scaled[i] <= (quot[27:RECIP_100_SHIFT] > 9'(DUTY_MAX)) ? DUTY_MAX
                     : quot[RECIP_100_SHIFT+7:RECIP_100_SHIFT];
      end
    end
    if (cmd.load_out) begin
      duty <= '{r: scaled[0], g: scaled[1], b: scaled[2]};
    end
  end

  assign m_tdata = duty;

endmodule

// ===== sv/rgb_led_pattern_engine.sv =====
// ----------------------------------------------------------------------------
// rgb_led_pattern_engine
// One RGB LED pattern engine: each tick gives one PWM duty triple.
// ----------------------------------------------------------------------------
// After a tick is accepted the sequencer walks the step timing, hue, base color
//   and two shared multiply/reciprocal passes; no new tick is taken until it is
//   back in idle. m_tvalid rises as the output register is loaded, which waits while an earlier result is unclaimed.
// A waiting result sits in the output register while the next tick is taken.
// Reset (rst, synchronous): registers to color blue, pattern pulse, 80 %.
module rgb_led_pattern_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] timestamp_ms
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] red_duty, [15:8] green_duty, [23:16] blue_duty
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);
  import rlpe_pkg::*;

  dp_cmd_t cmd;

  rlpe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  rlpe_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tdata   (m_tdata)
  );

endmodule

// ===== sv/rlpe_checker.sv =====
// ----------------------------------------------------------------------------
// rlpe_checker
// Port-level checks on the pattern engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rlpe_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // stalled result holds
  `ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result dropped or changed under stall")

  // one tick in flight: input closes right after an accept
  `ASSERT_CLK(a_one_in_flight, s_tvalid && s_tready |=> !s_tready, "second tick taken while busy")

  // reset leaves the engine empty and ready
  `ASSERT_ALWAYS(a_reset_idle, rst |=> !m_tvalid && s_tready, "engine not idle after reset")

endmodule

bind rgb_led_pattern_engine rlpe_checker u_rlpe_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
